// ===== rtl/core/rwlm_pkg.sv =====
package rwlm_pkg;

    // Request operation codes (carried on s_tuser)
    localparam logic [1:0] OP_READ   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_UNLOCK = 2'd2;

    // Result event codes (carried on m_tuser)
    localparam logic [2:0] EV_GRANTED = 3'd0;
    localparam logic [2:0] EV_QUEUED  = 3'd1;
    localparam logic [2:0] EV_RELEASE = 3'd2;
    localparam logic [2:0] EV_WAKE    = 3'd3;
    localparam logic [2:0] EV_NFOUND  = 3'd4;
    localparam logic [2:0] EV_FULL    = 3'd5;

    localparam int KEY_W   = 32;
    localparam int TID_W   = 16;
    localparam int ENTRY_W = TID_W + 1;

    // Waiters woken by one unlock at most
    localparam int WAKE_LIMIT = 16;

    localparam int NUM_RESOURCES_DEF = 16;
    localparam int MAX_HOLDERS_DEF   = 16;
    localparam int MAX_WAITERS_DEF   = 16;

    typedef struct packed {
        logic [2:0]       kind;
        logic [TID_W-1:0] thr;
        logic             mode;
        logic             last;
    } result_t;

endpackage

// ===== rtl/core/rwlm_ram.sv =====
module rwlm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/rwlm_obuf.sv =====
module rwlm_obuf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  rwlm_pkg::result_t res,
    output logic              out_free,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,  // granted_thread[15:0], granted_mode[16], zero pad
    output logic [2:0]        m_tuser,  // event_kind[2:0]
    output logic              m_tlast
);
    import rwlm_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign out_free = !valid_reg || m_tready;

    // Hold one result transaction until the receiver takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (push) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
        if (push) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {7'd0, res_reg.mode, res_reg.thr};
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.last;

endmodule

// ===== rtl/core/rwlm_ctrl.sv =====
module rwlm_ctrl #(
    parameter int NUM_RESOURCES = rwlm_pkg::NUM_RESOURCES_DEF,
    parameter int MAX_HOLDERS   = rwlm_pkg::MAX_HOLDERS_DEF,
    parameter int MAX_WAITERS   = rwlm_pkg::MAX_WAITERS_DEF,
    parameter int SW  = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1,
    parameter int HAW = (NUM_RESOURCES * MAX_HOLDERS > 1) ?
                        $clog2(NUM_RESOURCES * MAX_HOLDERS) : 1,
    parameter int WAW = (NUM_RESOURCES * MAX_WAITERS > 1) ?
                        $clog2(NUM_RESOURCES * MAX_WAITERS) : 1,
    parameter int HCW = $clog2(MAX_HOLDERS + 1),
    parameter int WHW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1,
    parameter int WCW = $clog2(MAX_WAITERS + 1),
    parameter int MW  = rwlm_pkg::KEY_W + 1 + rwlm_pkg::TID_W + HCW + WHW + WCW
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [1:0]                     s_op,
    input  logic [rwlm_pkg::KEY_W-1:0]     s_key,
    input  logic [rwlm_pkg::TID_W-1:0]     s_tid,
    output logic                           m_we,
    output logic [SW-1:0]                  m_waddr,
    output logic [MW-1:0]                  m_wdata,
    output logic [SW-1:0]                  m_raddr,
    input  logic [MW-1:0]                  m_rdata,
    output logic                           h_we,
    output logic [HAW-1:0]                 h_waddr,
    output logic [rwlm_pkg::ENTRY_W-1:0]   h_wdata,
    output logic [HAW-1:0]                 h_raddr,
    input  logic [rwlm_pkg::ENTRY_W-1:0]   h_rdata,
    output logic                           w_we,
    output logic [WAW-1:0]                 w_waddr,
    output logic [rwlm_pkg::ENTRY_W-1:0]   w_wdata,
    output logic [WAW-1:0]                 w_raddr,
    input  logic [rwlm_pkg::ENTRY_W-1:0]   w_rdata,
    input  logic                           out_free,
    output logic                           push,
    output rwlm_pkg::result_t              res
);
    import rwlm_pkg::*;

    localparam int SCW = $clog2(NUM_RESOURCES + 1);
    localparam int WKW = $clog2(WAKE_LIMIT + 1);
    localparam int PW  = WCW + 1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_S_RD, ST_S_CHK, ST_LOCK, ST_ONE, ST_U_RD, ST_U_CHK,
        ST_SH_RD, ST_SH_CHK, ST_SC_RD, ST_SC_CHK, ST_W_RD, ST_W_CHK, ST_FIN
    } state_t;

    state_t                   state_reg, state_next;
    logic [1:0]               op_reg, op_next;
    logic [KEY_W-1:0]         key_reg, key_next;
    logic [TID_W-1:0]         tid_reg, tid_next;
    logic [NUM_RESOURCES-1:0] used_reg, used_next;
    logic [SCW-1:0]           scan_reg, scan_next;
    logic [SW-1:0]            free_reg, free_next;
    logic                     free_vld_reg, free_vld_next;
    logic [SW-1:0]            slot_reg, slot_next;
    logic                     whld_reg, whld_next;
    logic [TID_W-1:0]         wthr_reg, wthr_next;
    logic [HCW-1:0]           hcnt_reg, hcnt_next;
    logic [WHW-1:0]           whead_reg, whead_next;
    logic [WCW-1:0]           wcnt_reg, wcnt_next;
    logic [HCW-1:0]           hix_reg, hix_next;
    logic                     mode_reg, mode_next;
    logic [WKW-1:0]           wakes_reg, wakes_next;
    logic                     wb_reg, wb_next;
    logic [2:0]               pkind_reg, pkind_next;
    logic [TID_W-1:0]         pthr_reg, pthr_next;
    logic                     pmode_reg, pmode_next;
    logic [SW-1:0]            mra_reg, mra_next;
    logic [HAW-1:0]           hra_reg, hra_next;
    logic [WAW-1:0]           wra_reg, wra_next;

    // Decoded slot word, lowest field first
    logic [WCW-1:0]   rd_wcnt;
    logic [WHW-1:0]   rd_whead;
    logic [HCW-1:0]   rd_hcnt;
    logic [TID_W-1:0] rd_wthr;
    logic             rd_whld;
    logic [KEY_W-1:0] rd_key;
    assign {rd_key, rd_whld, rd_wthr, rd_hcnt, rd_whead, rd_wcnt} = m_rdata;

    logic           must_wait;
    logic [PW-1:0]  wpos_sum;
    logic [WHW-1:0] wpos;
    logic [WHW-1:0] whead_inc;
    logic           wmode;
    logic           wake_ok;
    logic           freed;

    function automatic logic [HAW-1:0] haddr(input logic [SW-1:0] s, input logic [HCW-1:0] i);
        haddr = HAW'(s) * HAW'(MAX_HOLDERS) + HAW'(i);
    endfunction

    function automatic logic [WAW-1:0] waddr(input logic [SW-1:0] s, input logic [WHW-1:0] i);
        waddr = WAW'(s) * WAW'(MAX_WAITERS) + WAW'(i);
    endfunction

    assign must_wait = whld_reg ? (wthr_reg != tid_reg) :
                       (op_reg == OP_WRITE) ? (hcnt_reg != '0 || wcnt_reg != '0) :
                       (wcnt_reg != '0);
    assign wpos_sum  = PW'(whead_reg) + PW'(wcnt_reg);
    assign wpos      = (wpos_sum >= PW'(MAX_WAITERS)) ?
                       WHW'(wpos_sum - PW'(MAX_WAITERS)) : WHW'(wpos_sum);
    assign whead_inc = (PW'(whead_reg) + PW'(1) == PW'(MAX_WAITERS)) ? '0 :
                       WHW'(PW'(whead_reg) + PW'(1));
    assign wmode     = w_rdata[TID_W];
    assign wake_ok   = (wcnt_reg != '0) && !whld_reg && (wakes_reg < WKW'(WAKE_LIMIT))
                       && !(wmode && hcnt_reg != '0)
                       && (hcnt_reg < HCW'(MAX_HOLDERS));
    assign freed     = (hcnt_reg == '0) && (wcnt_reg == '0);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_raddr  = mra_next;
    assign h_raddr  = hra_next;
    assign w_raddr  = wra_next;

    // Sequence one request through the slot, holder and waiter memories
    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        tid_next      = tid_reg;
        used_next     = used_reg;
        scan_next     = scan_reg;
        free_next     = free_reg;
        free_vld_next = free_vld_reg;
        slot_next     = slot_reg;
        whld_next     = whld_reg;
        wthr_next     = wthr_reg;
        hcnt_next     = hcnt_reg;
        whead_next    = whead_reg;
        wcnt_next     = wcnt_reg;
        hix_next      = hix_reg;
        mode_next     = mode_reg;
        wakes_next    = wakes_reg;
        wb_next       = wb_reg;
        pkind_next    = pkind_reg;
        pthr_next     = pthr_reg;
        pmode_next    = pmode_reg;
        mra_next      = mra_reg;
        hra_next      = hra_reg;
        wra_next      = wra_reg;
        m_we          = 1'b0;
        m_waddr       = slot_reg;
        m_wdata       = {key_reg, whld_reg, wthr_reg, hcnt_reg, whead_reg, wcnt_reg};
        h_we          = 1'b0;
        h_waddr       = haddr(slot_reg, hix_reg);
        h_wdata       = h_rdata;
        w_we          = 1'b0;
        w_waddr       = waddr(slot_reg, wpos);
        w_wdata       = {op_reg[0], tid_reg};
        push          = 1'b0;
        res           = '{kind: pkind_reg, thr: pthr_reg, mode: pmode_reg, last: 1'b1};

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next       = s_op;
                    key_next      = s_key;
                    tid_next      = s_tid;
                    scan_next     = '0;
                    free_vld_next = 1'b0;
                    if (s_op == OP_READ || s_op == OP_WRITE || s_op == OP_UNLOCK) begin
                        state_next = ST_S_RD;
                    end
                end
            end
            // Walk the slot table, one slot per read
            ST_S_RD: begin
                if (scan_reg == SCW'(NUM_RESOURCES)) begin
                    wb_next = 1'b0;
                    if (op_reg == OP_UNLOCK) begin
                        pkind_next = EV_NFOUND;
                        pthr_next  = tid_reg;
                        pmode_next = 1'b0;
                        state_next = ST_ONE;
                    end else if (!free_vld_reg) begin
                        pkind_next = EV_FULL;
                        pthr_next  = tid_reg;
                        pmode_next = op_reg[0];
                        state_next = ST_ONE;
                    end else begin
                        slot_next  = free_reg;
                        whld_next  = 1'b0;
                        hcnt_next  = '0;
                        whead_next = '0;
                        wcnt_next  = '0;
                        state_next = ST_LOCK;
                    end
                end else begin
                    mra_next = scan_reg[SW-1:0];
                    if (!used_reg[scan_reg[SW-1:0]] && !free_vld_reg) begin
                        free_next     = scan_reg[SW-1:0];
                        free_vld_next = 1'b1;
                    end
                    state_next = ST_S_CHK;
                end
            end
            ST_S_CHK: begin
                if (used_reg[mra_reg] && rd_key == key_reg) begin
                    slot_next  = mra_reg;
                    whld_next  = rd_whld;
                    wthr_next  = rd_wthr;
                    hcnt_next  = rd_hcnt;
                    whead_next = rd_whead;
                    wcnt_next  = rd_wcnt;
                    if (op_reg != OP_UNLOCK) begin
                        state_next = ST_LOCK;
                    end else if (rd_hcnt == '0) begin
                        wb_next    = 1'b0;
                        pkind_next = EV_NFOUND;
                        pthr_next  = tid_reg;
                        pmode_next = 1'b0;
                        state_next = ST_ONE;
                    end else begin
                        hix_next   = rd_hcnt - HCW'(1);
                        state_next = ST_U_RD;
                    end
                end else begin
                    scan_next  = scan_reg + SCW'(1);
                    state_next = ST_S_RD;
                end
            end
            // Grant, queue or refuse a lock request
            ST_LOCK: begin
                wb_next    = 1'b1;
                pthr_next  = tid_reg;
                pmode_next = op_reg[0];
                pkind_next = EV_FULL;
                if (must_wait) begin
                    if (wcnt_reg < WCW'(MAX_WAITERS)) begin
                        w_we       = 1'b1;
                        wcnt_next  = wcnt_reg + WCW'(1);
                        pkind_next = EV_QUEUED;
                    end
                end else if (hcnt_reg < HCW'(MAX_HOLDERS)) begin
                    h_we       = 1'b1;
                    h_waddr    = haddr(slot_reg, hcnt_reg);
                    h_wdata    = {op_reg[0], tid_reg};
                    hcnt_next  = hcnt_reg + HCW'(1);
                    pkind_next = EV_GRANTED;
                    if (op_reg == OP_WRITE) begin
                        whld_next = 1'b1;
                        wthr_next = tid_reg;
                    end
                end
                state_next = ST_ONE;
            end
            ST_ONE: begin
                if (out_free) begin
                    push       = 1'b1;
                    state_next = wb_reg ? ST_FIN : ST_IDLE;
                end
            end
            // Search holders newest first for the unlocking thread
            ST_U_RD: begin
                hra_next   = haddr(slot_reg, hix_reg);
                state_next = ST_U_CHK;
            end
            ST_U_CHK: begin
                if (h_rdata[TID_W-1:0] == tid_reg) begin
                    mode_next  = h_rdata[TID_W];
                    state_next = ST_SH_RD;
                end else if (hix_reg == '0) begin
                    wb_next    = 1'b0;
                    pkind_next = EV_NFOUND;
                    pthr_next  = tid_reg;
                    pmode_next = 1'b0;
                    state_next = ST_ONE;
                end else begin
                    hix_next   = hix_reg - HCW'(1);
                    state_next = ST_U_RD;
                end
            end
            // Close the gap left by the removed hold
            ST_SH_RD: begin
                if (hix_reg + HCW'(1) < hcnt_reg) begin
                    hra_next   = haddr(slot_reg, hix_reg + HCW'(1));
                    state_next = ST_SH_CHK;
                end else begin
                    hcnt_next = hcnt_reg - HCW'(1);
                    hix_next  = '0;
                    if (mode_reg) begin
                        whld_next  = 1'b0;
                        state_next = ST_SC_RD;
                    end else begin
                        pkind_next = EV_RELEASE;
                        pthr_next  = tid_reg;
                        pmode_next = mode_reg;
                        wakes_next = '0;
                        state_next = ST_W_RD;
                    end
                end
            end
            ST_SH_CHK: begin
                h_we       = 1'b1;
                hix_next   = hix_reg + HCW'(1);
                state_next = ST_SH_RD;
            end
            // Rebuild the writer mark from the remaining holds
            ST_SC_RD: begin
                if (hix_reg < hcnt_reg) begin
                    hra_next   = haddr(slot_reg, hix_reg);
                    state_next = ST_SC_CHK;
                end else begin
                    pkind_next = EV_RELEASE;
                    pthr_next  = tid_reg;
                    pmode_next = mode_reg;
                    wakes_next = '0;
                    state_next = ST_W_RD;
                end
            end
            ST_SC_CHK: begin
                if (h_rdata[TID_W]) begin
                    whld_next = 1'b1;
                end
                hix_next   = hix_reg + HCW'(1);
                state_next = ST_SC_RD;
            end
            // Wake waiters in order; the pending result learns its last flag here
            ST_W_RD: begin
                wra_next   = waddr(slot_reg, whead_reg);
                state_next = ST_W_CHK;
            end
            ST_W_CHK: begin
                if (out_free) begin
                    push     = 1'b1;
                    res.last = !wake_ok;
                    if (wake_ok) begin
                        h_we       = 1'b1;
                        h_waddr    = haddr(slot_reg, hcnt_reg);
                        h_wdata    = w_rdata;
                        hcnt_next  = hcnt_reg + HCW'(1);
                        whead_next = whead_inc;
                        wcnt_next  = wcnt_reg - WCW'(1);
                        wakes_next = wakes_reg + WKW'(1);
                        if (wmode) begin
                            whld_next = 1'b1;
                            wthr_next = w_rdata[TID_W-1:0];
                        end
                        pkind_next = EV_WAKE;
                        pthr_next  = w_rdata[TID_W-1:0];
                        pmode_next = wmode;
                        state_next = ST_W_RD;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            // Write the slot back, freeing it when nothing is left
            ST_FIN: begin
                m_we = 1'b1;
                if (freed) begin
                    used_next[slot_reg] = 1'b0;
                    m_wdata = {key_reg, 1'b0, wthr_reg, hcnt_reg, WHW'(0), wcnt_reg};
                end else begin
                    used_next[slot_reg] = 1'b1;
                end
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            used_reg  <= '0;
            hcnt_reg  <= '0;
            wcnt_reg  <= '0;
            wakes_reg <= '0;
        end else begin
            state_reg <= state_next;
            used_reg  <= used_next;
            hcnt_reg  <= hcnt_next;
            wcnt_reg  <= wcnt_next;
            wakes_reg <= wakes_next;
        end
        op_reg       <= op_next;
        key_reg      <= key_next;
        tid_reg      <= tid_next;
        scan_reg     <= scan_next;
        free_reg     <= free_next;
        free_vld_reg <= free_vld_next;
        slot_reg     <= slot_next;
        whld_reg     <= whld_next;
        wthr_reg     <= wthr_next;
        whead_reg    <= whead_next;
        hix_reg      <= hix_next;
        mode_reg     <= mode_next;
        wb_reg       <= wb_next;
        pkind_reg    <= pkind_next;
        pthr_reg     <= pthr_next;
        pmode_reg    <= pmode_next;
        mra_reg      <= mra_next;
        hra_reg      <= hra_next;
        wra_reg      <= wra_next;
    end

    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> out_free) else $error("result pushed into a full output stage");
    a_hcnt: assert property (@(posedge aclk) disable iff (!aresetn)
        hcnt_reg <= HCW'(MAX_HOLDERS)) else $error("holder count overflow");
    a_wcnt: assert property (@(posedge aclk) disable iff (!aresetn)
        wcnt_reg <= WCW'(MAX_WAITERS)) else $error("waiter count overflow");
    a_wakes: assert property (@(posedge aclk) disable iff (!aresetn)
        wakes_reg <= WKW'(WAKE_LIMIT)) else $error("wake limit exceeded");
    a_one_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !(h_we && w_we)) else $error("holder and waiter written together");

endmodule

// ===== rtl/core/reader_writer_lock_manager_unit.sv =====
// Reader/writer lock table with FIFO-fair waiting.
// Input channel s_*: one transaction per request. s_tuser holds the operation
// (read lock, write lock, unlock); s_tdata holds the resource key and thread id.
// Output channel m_*: one or more result transactions per lock or unlock request,
// the final one marked by m_tlast. A successful unlock gives a release result
// followed by one result per woken waiter (at most sixteen).
// A request is taken only when the block is idle. It first walks the slot memory
// one slot at a time until the key matches. A lock on a found or free slot then
// decides, presents the result and writes the slot back. An unlock searches the
// holders newest first, shifts the later holds down, rescans them after a write
// unlock, wakes waiters in order, makes a final wake check and writes the slot
// back, all through the single read port of the holder and waiter memories.
// Reset clears the slot-used bits and all control state; the memories need no
// clearing pass, so a request may be taken in the first cycle after reset.
// A stalled receiver holds the result register and the sequencer waits on it;
// no result is dropped.
module reader_writer_lock_manager_unit #(
    parameter int NUM_RESOURCES = rwlm_pkg::NUM_RESOURCES_DEF,
    parameter int MAX_HOLDERS   = rwlm_pkg::MAX_HOLDERS_DEF,
    parameter int MAX_WAITERS   = rwlm_pkg::MAX_WAITERS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // resource_id[31:0], thread_id[47:32]
    input  logic [1:0]  s_tuser,  // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // granted_thread[15:0], granted_mode[16], zero pad
    output logic [2:0]  m_tuser,  // event_kind[2:0]
    output logic        m_tlast
);
    import rwlm_pkg::*;

    localparam int SW  = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
    localparam int HD  = NUM_RESOURCES * MAX_HOLDERS;
    localparam int WD  = NUM_RESOURCES * MAX_WAITERS;
    localparam int HAW = (HD > 1) ? $clog2(HD) : 1;
    localparam int WAW = (WD > 1) ? $clog2(WD) : 1;
    localparam int HCW = $clog2(MAX_HOLDERS + 1);
    localparam int WHW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int WCW = $clog2(MAX_WAITERS + 1);
    localparam int MW  = KEY_W + 1 + TID_W + HCW + WHW + WCW;

    logic               m_we, h_we, w_we;
    logic [SW-1:0]      m_waddr, m_raddr;
    logic [MW-1:0]      m_wdata, m_rdata;
    logic [HAW-1:0]     h_waddr, h_raddr;
    logic [WAW-1:0]     w_waddr, w_raddr;
    logic [ENTRY_W-1:0] h_wdata, h_rdata, w_wdata, w_rdata;
    logic               out_free, push;
    result_t            res;

    rwlm_ram #(.WIDTH(MW), .DEPTH(NUM_RESOURCES)) u_slot_ram (
        .aclk(aclk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
        .raddr(m_raddr), .rdata(m_rdata)
    );

    rwlm_ram #(.WIDTH(ENTRY_W), .DEPTH(HD)) u_holder_ram (
        .aclk(aclk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
        .raddr(h_raddr), .rdata(h_rdata)
    );

    rwlm_ram #(.WIDTH(ENTRY_W), .DEPTH(WD)) u_waiter_ram (
        .aclk(aclk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
        .raddr(w_raddr), .rdata(w_rdata)
    );

    rwlm_ctrl #(
        .NUM_RESOURCES(NUM_RESOURCES),
        .MAX_HOLDERS(MAX_HOLDERS),
        .MAX_WAITERS(MAX_WAITERS)
    ) u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_op(s_tuser), .s_key(s_tdata[31:0]), .s_tid(s_tdata[47:32]),
        .m_we(m_we), .m_waddr(m_waddr), .m_wdata(m_wdata),
        .m_raddr(m_raddr), .m_rdata(m_rdata),
        .h_we(h_we), .h_waddr(h_waddr), .h_wdata(h_wdata),
        .h_raddr(h_raddr), .h_rdata(h_rdata),
        .w_we(w_we), .w_waddr(w_waddr), .w_wdata(w_wdata),
        .w_raddr(w_raddr), .w_rdata(w_rdata),
        .out_free(out_free), .push(push), .res(res)
    );

    rwlm_obuf u_obuf (
        .aclk(aclk), .aresetn(aresetn), .push(push), .res(res),
        .out_free(out_free), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

endmodule
